>>> hw/rtl/fetp_pkg.sv
// ----------------------------------------------------------------------------
// fetp_pkg
// Shared types and constants for the escape-time fractal pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fetp_pkg;

  localparam int DATA_W   = 32;             // Q-format word, config data width
  localparam int PROD_W   = 2 * DATA_W;     // full product width
  localparam int STEP_W   = 31;
  localparam int COLOR_W  = 24;
  localparam int CFG_IDX_W = 3;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_RE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_IM   = 3'd6;

  // Reset values
  localparam logic [DATA_W-1:0] RST_ORIGIN_RE  = 32'hFE00_0000;  // -2.0
  localparam logic [DATA_W-1:0] RST_ORIGIN_IM  = 32'h0200_0000;  // +2.0
  localparam logic [STEP_W-1:0] RST_PIXEL_STEP = 31'd67109;
  localparam int                RST_MAX_ITER   = 60;
  localparam logic              RST_MODE       = 1'b1;
  localparam logic [DATA_W-1:0] RST_JULIA_RE   = 32'hFF61_C886;  // -10368890
  localparam logic [DATA_W-1:0] RST_JULIA_IM   = 32'h0000_0000;

  localparam logic MODE_JULIA      = 1'b0;
  localparam logic MODE_MANDELBROT = 1'b1;

  localparam int ESCAPE_RADIUS_SQ = 4;
  localparam int BAND_WIDTH       = 10;
  localparam int NUM_BANDS        = 6;

  localparam logic [COLOR_W-1:0] BAND_COLOR [NUM_BANDS] =
    '{24'd200, 24'd400, 24'd600, 24'd800, 24'd900, 24'd1100};
  localparam logic [COLOR_W-1:0] OUTER_COLOR        = 24'd1000;
  localparam logic [COLOR_W-1:0] BLACK_COLOR        = 24'd0;
  localparam logic [COLOR_W-1:0] JULIA_INSIDE_COLOR = 24'hFFFF00;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b0_0000_0001,
    ST_MAP_RE = 9'b0_0000_0010,
    ST_MAP_IM = 9'b0_0000_0100,
    ST_SETUP  = 9'b0_0000_1000,
    ST_SQ_A   = 9'b0_0001_0000,
    ST_SQ_B   = 9'b0_0010_0000,
    ST_X_AB   = 9'b0_0100_0000,
    ST_UPDATE = 9'b0_1000_0000,
    ST_FINISH = 9'b1_0000_0000
  } state_t;

  // Clamp a 64-bit signed value to the 32-bit signed range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic hi_any;
    logic hi_all;
    begin
      hi_any = |v[PROD_W-2:DATA_W-1];
      hi_all = &v[PROD_W-2:DATA_W-1];
      if (!v[PROD_W-1] && hi_any) begin
        sat32 = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v[PROD_W-1] && !hi_all) begin
        sat32 = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        sat32 = v[DATA_W-1:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fetp_if.sv
// ----------------------------------------------------------------------------
// fetp_in_if / fetp_out_if
// Valid/ready channels for pixel requests and escape-time results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fetp_in_if #(parameter int COORD_BITS = 10);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface fetp_out_if #(parameter int ITER_BITS = 12);
  logic                          valid;
  logic                          ready;
  logic [ITER_BITS-1:0]          iteration_count;
  logic [fetp_pkg::COLOR_W-1:0]  pixel_color;

  modport source (output valid, output iteration_count, output pixel_color, input ready);
  modport sink   (input valid, input iteration_count, input pixel_color, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fetp_mul.sv
// ----------------------------------------------------------------------------
// fetp_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module fetp_mul (
  input  wire logic                                  clk,
  input  wire logic signed [fetp_pkg::DATA_W-1:0]    op_a,
  input  wire logic signed [fetp_pkg::DATA_W-1:0]    op_b,
  output logic      signed [fetp_pkg::PROD_W-1:0]    prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

`default_nettype wire

>>> hw/rtl/fractal_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// fractal_escape_time_pixel
// Escape-time Mandelbrot / Julia pixel engine in signed fixed point.
// ----------------------------------------------------------------------------
// Each request carries one pixel (column, row). The pixel is mapped to the
// point re = origin_re + col*step, im = origin_im - row*step, and z <- z^2 + k
// is iterated until |z|^2 >= 4 or max_iterations steps are done. Mandelbrot
// mode (fractal_mode = 1) starts z at 0 and adds the point; Julia mode starts
// z at the point and adds (julia_c_re, -julia_c_im). The result carries the
// step count and a 24-bit color. All multiplications run through one shared
// registered 32x32 multiplier, which forms col*step and row*step for the
// point mapping and then a*a, b*b and a*b in turn for each step. A step runs
// through ST_SQ_A (limit check), ST_SQ_B, ST_X_AB (escape test) and
// ST_UPDATE; the point mapping runs through ST_MAP_RE, ST_MAP_IM and
// ST_SETUP, and the result is loaded in ST_FINISH. One pixel is in flight at
// a time; in_pix.ready is high only while the engine is idle, from the
// cycle after the result load at the earliest. The result sits in an
// output register, so the next pixel can be taken while the previous
// result waits. Configuration writes (cfg_we, cfg_index, cfg_data) must
// only happen while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fractal_escape_time_pixel #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 24,
  parameter int ITER_BITS  = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  fetp_in_if.sink                                 in_pix,
  fetp_out_if.source                              out_res,
  input  wire logic                               cfg_we,
  input  wire logic [fetp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fetp_pkg::DATA_W-1:0]        cfg_data
);

  localparam int DW  = fetp_pkg::DATA_W;
  localparam int PW  = fetp_pkg::PROD_W;
  localparam int CW  = ITER_BITS + 2;   // signed width for band thresholds
  localparam logic [PW-1:0] ESC_BOUND =
    PW'(fetp_pkg::ESCAPE_RADIUS_SQ) << (2 * FRAC_BITS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [DW-1:0]                origin_re_r;
  logic signed [DW-1:0]                origin_im_r;
  logic [fetp_pkg::STEP_W-1:0]         pixel_step_r;
  logic [ITER_BITS-1:0]                max_iter_r;
  logic                                mode_r;
  logic signed [DW-1:0]                julia_re_r;
  logic signed [DW-1:0]                julia_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_re_r  <= fetp_pkg::RST_ORIGIN_RE;
      origin_im_r  <= fetp_pkg::RST_ORIGIN_IM;
      pixel_step_r <= fetp_pkg::RST_PIXEL_STEP;
      max_iter_r   <= ITER_BITS'(fetp_pkg::RST_MAX_ITER);
      mode_r       <= fetp_pkg::RST_MODE;
      julia_re_r   <= fetp_pkg::RST_JULIA_RE;
      julia_im_r   <= fetp_pkg::RST_JULIA_IM;
    end else if (cfg_we) begin
      case (cfg_index)
        fetp_pkg::CFG_ORIGIN_RE:  origin_re_r  <= cfg_data;
        fetp_pkg::CFG_ORIGIN_IM:  origin_im_r  <= cfg_data;
        fetp_pkg::CFG_PIXEL_STEP: pixel_step_r <= cfg_data[fetp_pkg::STEP_W-1:0];
        fetp_pkg::CFG_MAX_ITER:   max_iter_r   <= cfg_data[ITER_BITS-1:0];
        fetp_pkg::CFG_MODE:       mode_r       <= cfg_data[0];
        fetp_pkg::CFG_JULIA_RE:   julia_re_r   <= cfg_data;
        fetp_pkg::CFG_JULIA_IM:   julia_im_r   <= cfg_data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  fetp_pkg::state_t state_r, state_nxt;

  logic [COORD_BITS-1:0]  col_r, col_nxt;
  logic [COORD_BITS-1:0]  row_r, row_nxt;
  logic signed [DW-1:0]   re_r, re_nxt;      // mapped real part
  logic signed [DW-1:0]   a_r, a_nxt;        // z real
  logic signed [DW-1:0]   b_r, b_nxt;        // z imaginary
  logic signed [DW-1:0]   k_re_r, k_re_nxt;
  logic signed [DW:0]     k_im_r, k_im_nxt;  // 33 bits; Julia: -julia_c_im
  logic signed [PW-1:0]   aa_r, aa_nxt;
  logic signed [PW-1:0]   diff_r, diff_nxt;
  logic [ITER_BITS-1:0]   n_r, n_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [ITER_BITS-1:0]   out_cnt_r, out_cnt_nxt;
  logic [fetp_pkg::COLOR_W-1:0] out_color_r, out_color_nxt;

  // Shared multiplier
  logic signed [DW-1:0]   mul_a;
  logic signed [DW-1:0]   mul_b;
  logic signed [PW-1:0]   prod;

  fetp_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  always_comb begin
    case (state_r)
      fetp_pkg::ST_MAP_RE: begin
        mul_a = DW'(col_r);
        mul_b = {1'b0, pixel_step_r};
      end
      fetp_pkg::ST_MAP_IM: begin
        mul_a = DW'(row_r);
        mul_b = {1'b0, pixel_step_r};
      end
      fetp_pkg::ST_SQ_A: begin
        mul_a = a_r;
        mul_b = a_r;
      end
      fetp_pkg::ST_SQ_B: begin
        mul_a = b_r;
        mul_b = b_r;
      end
      default: begin      // a*b in ST_X_AB; don't care elsewhere
        mul_a = a_r;
        mul_b = b_r;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Color lookup from the final count
  // --------------------------------------------------------------------------
  logic [fetp_pkg::COLOR_W-1:0] color;
  logic signed [CW-1:0]         cnt_s;
  logic signed [CW-1:0]         lim_s;

  always_comb begin
    cnt_s = $signed({2'b00, n_r});
    lim_s = $signed({2'b00, max_iter_r});
    if (mode_r == fetp_pkg::MODE_MANDELBROT) begin
      if (n_r == max_iter_r) begin
        color = fetp_pkg::BLACK_COLOR;
      end else begin
        color = (n_r != '0) ? fetp_pkg::OUTER_COLOR : fetp_pkg::BLACK_COLOR;
        // walk from the outermost band in so the innermost match wins
        for (int k = fetp_pkg::NUM_BANDS - 1; k >= 0; k--) begin
          if (cnt_s > lim_s - CW'(fetp_pkg::BAND_WIDTH * (k + 1))) begin
            color = fetp_pkg::BAND_COLOR[k];
          end
        end
      end
    end else begin
      color = (n_r == max_iter_r) ? fetp_pkg::JULIA_INSIDE_COLOR
                                  : fetp_pkg::BLACK_COLOR;
    end
  end

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  logic [PW-1:0]        mag_sq;
  logic signed [PW-1:0] im_full;
  logic signed [DW-1:0] im_sat;
  logic signed [PW-1:0] a_full;
  logic signed [PW-1:0] b_full;

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    re_nxt        = re_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_re_nxt      = k_re_r;
    k_im_nxt      = k_im_r;
    aa_nxt        = aa_r;
    diff_nxt      = diff_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r;
    out_cnt_nxt   = out_cnt_r;
    out_color_nxt = out_color_r;

    // bb arrives on prod during ST_X_AB
    mag_sq  = $unsigned(aa_r) + $unsigned(prod);
    im_full = PW'(origin_im_r) - prod;
    im_sat  = fetp_pkg::sat32(im_full);
    a_full  = (diff_r >>> FRAC_BITS) + PW'(k_re_r);
    b_full  = (prod >>> (FRAC_BITS - 1)) + PW'(k_im_r);

    if (out_res.valid && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      fetp_pkg::ST_IDLE: begin
        if (in_pix.valid) begin
          col_nxt   = in_pix.pixel_col;
          row_nxt   = in_pix.pixel_row;
          state_nxt = fetp_pkg::ST_MAP_RE;
        end
      end
      fetp_pkg::ST_MAP_RE: begin
        state_nxt = fetp_pkg::ST_MAP_IM;
      end
      fetp_pkg::ST_MAP_IM: begin
        re_nxt    = fetp_pkg::sat32(PW'(origin_re_r) + prod);
        state_nxt = fetp_pkg::ST_SETUP;
      end
      fetp_pkg::ST_SETUP: begin
        n_nxt = '0;
        if (mode_r == fetp_pkg::MODE_MANDELBROT) begin
          a_nxt    = '0;
          b_nxt    = '0;
          k_re_nxt = re_r;
          k_im_nxt = (DW + 1)'(im_sat);
        end else begin
          a_nxt    = re_r;
          b_nxt    = im_sat;
          k_re_nxt = julia_re_r;
          k_im_nxt = -((DW + 1)'(julia_im_r));
        end
        state_nxt = fetp_pkg::ST_SQ_A;
      end
      fetp_pkg::ST_SQ_A: begin
        // limit check before each step; multiplier forms a*a meanwhile
        state_nxt = (n_r == max_iter_r) ? fetp_pkg::ST_FINISH : fetp_pkg::ST_SQ_B;
      end
      fetp_pkg::ST_SQ_B: begin
        aa_nxt    = prod;
        state_nxt = fetp_pkg::ST_X_AB;
      end
      fetp_pkg::ST_X_AB: begin
        diff_nxt  = aa_r - prod;
        state_nxt = (mag_sq >= ESC_BOUND) ? fetp_pkg::ST_FINISH : fetp_pkg::ST_UPDATE;
      end
      fetp_pkg::ST_UPDATE: begin
        a_nxt     = fetp_pkg::sat32(a_full);
        b_nxt     = fetp_pkg::sat32(b_full);
        n_nxt     = n_r + 1'b1;
        state_nxt = fetp_pkg::ST_SQ_A;
      end
      fetp_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = n_r;
          out_color_nxt = color;
          state_nxt     = fetp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fetp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fetp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    re_r        <= re_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    k_re_r      <= k_re_nxt;
    k_im_r      <= k_im_nxt;
    aa_r        <= aa_nxt;
    diff_r      <= diff_nxt;
    n_r         <= n_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_color_r <= out_color_nxt;
  end

  assign in_pix.ready            = (state_r == fetp_pkg::ST_IDLE);
  assign out_res.valid           = out_valid_r;
  assign out_res.iteration_count = out_cnt_r;
  assign out_res.pixel_color     = out_color_r;

endmodule

`default_nettype wire
